// ===== rtl/pss_pkg.sv =====
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types, widths, constants and the arctangent table for the polar
// phasor summation block.
// ----------------------------------------------------------------------------
package pss_pkg;

  // Field widths
  localparam int MAG_W  = 16;   // input magnitude, unsigned Q8.8
  localparam int PH_W   = 16;   // phase, signed fraction of pi
  localparam int SMAG_W = 21;   // output magnitude, unsigned Q13.8
  localparam int CNT_W  = 5;    // input_count register

  // Datapath widths
  localparam int ACC_W  = 26;   // real / imaginary accumulators, signed Q18.8
  localparam int X_W    = 37;   // CORDIC x / y, covers vectoring growth
  localparam int Z_W    = 33;   // CORDIC angle, pi = 2^31
  localparam int LO_W   = 18;   // low half of a split multiplier operand
  localparam int MUL_W  = X_W - LO_W;        // signed multiplier operand
  localparam int KG_W   = 17;                // signed gain operand
  localparam int MP_W   = MUL_W + KG_W;      // one partial product
  localparam int PROD_W = 55;                // full x * gain
  localparam int RND_SH = 24;
  localparam int RND_W  = PROD_W - RND_SH;
  localparam int ATAN_W = 30;
  localparam int IDX_W  = 5;    // CORDIC step index, covers up to 32 steps

  localparam logic signed [KG_W-1:0]  KGAIN    = 17'sd39797;
  localparam logic        [CNT_W-1:0] CNT_RST  = 5'd2;
  localparam logic [SMAG_W-1:0]       MAG_MAX  = {SMAG_W{1'b1}};

  // Defaults for top level parameters
  localparam int MAX_INPUTS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  typedef struct packed {
    logic [MAG_W-1:0]        magnitude;
    logic signed [PH_W-1:0]  phase;
    logic                    bin_last;
  } in_item_t;

  typedef struct packed {
    logic [SMAG_W-1:0]       sum_magnitude;
    logic signed [PH_W-1:0]  sum_phase;
    logic                    last_bin;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic             load_rot;   // capture an accepted item, fold quadrant
    logic             load_vec;   // move sum into CORDIC, clear accumulators
    logic             step;       // one CORDIC micro-rotation
    logic             vec_mode;   // vectoring direction rule
    logic [IDX_W-1:0] step_idx;
    logic             mul_lo;     // product = low half * gain
    logic             mul_hi;     // product += high half * gain << LO_W
    logic             mul_y;      // multiply y instead of x
    logic             acc_re;     // add rounded product to real sum
    logic             acc_im;     // add rounded product to imaginary sum
    logic             out_load;   // write result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_busy;
  } stat_t;

  // round(atan(2^-i) / pi * 2^31), zero past the table
  function automatic logic [ATAN_W-1:0] atan_at(input logic [IDX_W-1:0] i);
    logic [ATAN_W-1:0] a;
    case (i)
      5'd0:    a = 30'd536870912;
      5'd1:    a = 30'd316933406;
      5'd2:    a = 30'd167458907;
      5'd3:    a = 30'd85004756;
      5'd4:    a = 30'd42667331;
      5'd5:    a = 30'd21354465;
      5'd6:    a = 30'd10679838;
      5'd7:    a = 30'd5340245;
      5'd8:    a = 30'd2670163;
      5'd9:    a = 30'd1335087;
      5'd10:   a = 30'd667544;
      5'd11:   a = 30'd333772;
      5'd12:   a = 30'd166886;
      5'd13:   a = 30'd83443;
      5'd14:   a = 30'd41722;
      5'd15:   a = 30'd20861;
      5'd16:   a = 30'd10430;
      5'd17:   a = 30'd5215;
      5'd18:   a = 30'd2608;
      5'd19:   a = 30'd1304;
      5'd20:   a = 30'd652;
      5'd21:   a = 30'd326;
      5'd22:   a = 30'd163;
      5'd23:   a = 30'd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/pss_chan_if.sv =====
// ----------------------------------------------------------------------------
// pss_chan_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface pss_chan_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/pss_ctrl.sv =====
// ----------------------------------------------------------------------------
// pss_ctrl
// Sequencer: rotation per item, count per bin, vectoring per bin, result
// handoff. Holds the input_count register.
// ----------------------------------------------------------------------------
module pss_ctrl #(
  parameter int MAX_INPUTS   = pss_pkg::MAX_INPUTS_DEF,
  parameter int CORDIC_STEPS = pss_pkg::CORDIC_STEPS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  pss_chan_if.sink      cfg,
  output pss_pkg::cmd_t cmd,
  input  pss_pkg::stat_t stat
);

  localparam int SEEN_W = $clog2(MAX_INPUTS + 1);
  localparam int CMP_W  = ((SEEN_W > pss_pkg::CNT_W) ? SEEN_W : pss_pkg::CNT_W) + 1;
  localparam int STEP_W = $clog2(CORDIC_STEPS);

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_ROT  = 12'b0000_0000_0010,
    S_XLO  = 12'b0000_0000_0100,
    S_XHI  = 12'b0000_0000_1000,
    S_YLO  = 12'b0000_0001_0000,
    S_YHI  = 12'b0000_0010_0000,
    S_ACCI = 12'b0000_0100_0000,
    S_VLD  = 12'b0000_1000_0000,
    S_VEC  = 12'b0001_0000_0000,
    S_MLO  = 12'b0010_0000_0000,
    S_MHI  = 12'b0100_0000_0000,
    S_FIN  = 12'b1000_0000_0000
  } state_t;

  state_t                    st, st_next;
  logic [STEP_W-1:0]         step, step_next;
  logic [SEEN_W-1:0]         seen, seen_next;
  logic [pss_pkg::CNT_W-1:0] count;
  logic [CMP_W-1:0]          need, seen_inc;
  logic                      bin_done, step_last;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= pss_pkg::CNT_RST;
    end else if (cfg.valid) begin
      count <= cfg.data;
    end
  end

  // Zero counts as one, clamp at the maximum
  always_comb begin
    if (count == '0) begin
      need = CMP_W'(1);
    end else if (CMP_W'(count) > CMP_W'(MAX_INPUTS)) begin
      need = CMP_W'(MAX_INPUTS);
    end else begin
      need = CMP_W'(count);
    end
  end

  assign seen_inc  = CMP_W'(seen) + CMP_W'(1);
  assign bin_done  = (seen_inc >= need);
  assign step_last = (step == STEP_W'(CORDIC_STEPS - 1));

  always_comb begin
    st_next   = st;
    step_next = step;
    seen_next = seen;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.step_idx = pss_pkg::IDX_W'(step);
    unique case (st)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load_rot = 1'b1;
          st_next      = S_ROT;
        end
      end
      S_ROT: begin
        cmd.step = 1'b1;
        if (step_last) begin
          step_next = '0;
          st_next   = S_XLO;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      S_XLO: begin
        cmd.mul_lo = 1'b1;
        st_next    = S_XHI;
      end
      S_XHI: begin
        cmd.mul_hi = 1'b1;
        st_next    = S_YLO;
      end
      S_YLO: begin
        cmd.mul_lo = 1'b1;
        cmd.mul_y  = 1'b1;
        cmd.acc_re = 1'b1;
        st_next    = S_YHI;
      end
      S_YHI: begin
        cmd.mul_hi = 1'b1;
        cmd.mul_y  = 1'b1;
        st_next    = S_ACCI;
      end
      S_ACCI: begin
        cmd.acc_im = 1'b1;
        if (bin_done) begin
          seen_next = '0;
          st_next   = S_VLD;
        end else begin
          seen_next = SEEN_W'(seen_inc);
          st_next   = S_IDLE;
        end
      end
      S_VLD: begin
        cmd.load_vec = 1'b1;
        st_next      = S_VEC;
      end
      S_VEC: begin
        cmd.step     = 1'b1;
        cmd.vec_mode = 1'b1;
        if (step_last) begin
          step_next = '0;
          st_next   = S_MLO;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      S_MLO: begin
        cmd.mul_lo = 1'b1;
        st_next    = S_MHI;
      end
      S_MHI: begin
        cmd.mul_hi = 1'b1;
        st_next    = S_FIN;
      end
      S_FIN: begin
        // Hold until the result register is free
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          st_next      = S_IDLE;
        end
      end
      default: begin
        st_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= S_IDLE;
      step <= '0;
      seen <= '0;
    end else begin
      st   <= st_next;
      step <= step_next;
      seen <= seen_next;
    end
  end

`ifndef ASSERT_OFF
  a_accept_starts_rot: assert property (@(posedge clk) disable iff (rst)
    (st == S_IDLE && in_valid) |=> st == S_ROT)
    else $error("accepted beat did not start a rotation");
  a_seen_bounded: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(seen) < CMP_W'(MAX_INPUTS))
    else $error("inputs_seen reached the bin size without closing the bin");
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !stat.out_busy)
    else $error("result overwritten before it was taken");
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(st))
    else $error("state register not one-hot");
`endif

endmodule

// ===== rtl/pss_datapath.sv =====
// ----------------------------------------------------------------------------
// pss_datapath
// Shared CORDIC unit (rotation and vectoring), split gain multiplier,
// accumulators and result register.
// ----------------------------------------------------------------------------
module pss_datapath (
  input  logic              clk,
  input  logic              rst,
  input  pss_pkg::in_item_t in_data,
  input  pss_pkg::cmd_t     cmd,
  output pss_pkg::stat_t    stat,
  pss_chan_if.source        result
);

  localparam int X_W   = pss_pkg::X_W;
  localparam int Z_W   = pss_pkg::Z_W;
  localparam int ACC_W = pss_pkg::ACC_W;

  logic signed [X_W-1:0]            x, y, dx, dy, op;
  logic signed [Z_W-1:0]            z, ang;
  logic signed [ACC_W-1:0]          acc_re, acc_im;
  logic signed [pss_pkg::PROD_W-1:0] prod, prod_rnd;
  logic signed [pss_pkg::RND_W-1:0]  rnd;
  logic signed [pss_pkg::MUL_W-1:0]  m_in;
  logic signed [pss_pkg::MP_W-1:0]   mprod;
  logic                             last, zero_sum, sigma;

  // Rotation load: fold the phase into +-pi/2
  logic signed [pss_pkg::PH_W:0]    ph_ext, ph_fold;
  logic                             ph_flip;
  logic signed [X_W-1:0]            x_mag;
  // Vectoring load
  logic signed [X_W-1:0]            re_ext, im_ext;
  // Result shaping
  logic [pss_pkg::SMAG_W-1:0]       mag_sat;
  logic signed [Z_W-1:0]            z_rnd;
  pss_pkg::out_item_t               res;

  always_comb begin
    ph_ext  = (pss_pkg::PH_W + 1)'(in_data.phase);
    ph_flip = 1'b0;
    ph_fold = ph_ext;
    if (ph_ext > 17'sd16384) begin
      ph_flip = 1'b1;
      ph_fold = ph_ext - 17'sd32768;
    end else if (ph_ext < -17'sd16384) begin
      ph_flip = 1'b1;
      ph_fold = ph_ext + 17'sd32768;
    end
    x_mag = X_W'({in_data.magnitude, 8'd0});
  end

  assign re_ext = X_W'(acc_re) <<< 8;
  assign im_ext = X_W'(acc_im) <<< 8;

  // Micro-rotation: sigma set means x -= y>>i, y += x>>i, z -= atan
  assign dx    = y >>> cmd.step_idx;
  assign dy    = x >>> cmd.step_idx;
  assign ang   = Z_W'(pss_pkg::atan_at(cmd.step_idx));
  assign sigma = cmd.vec_mode ? y[X_W-1] : ~z[Z_W-1];

  // Gain multiply, split in two halves
  assign op    = cmd.mul_y ? y : x;
  assign m_in  = cmd.mul_hi ? op[X_W-1:pss_pkg::LO_W]
                            : $signed({1'b0, op[pss_pkg::LO_W-1:0]});
  assign mprod = m_in * pss_pkg::KGAIN;

  // Round half up by 2^24
  assign prod_rnd = prod + (pss_pkg::PROD_W'(1) <<< (pss_pkg::RND_SH - 1));
  assign rnd      = prod_rnd[pss_pkg::PROD_W-1:pss_pkg::RND_SH];

  always_ff @(posedge clk) begin
    if (cmd.load_rot) begin
      x    <= ph_flip ? -x_mag : x_mag;
      y    <= '0;
      z    <= Z_W'({ph_fold, 16'd0});
      last <= in_data.bin_last;
    end else if (cmd.load_vec) begin
      zero_sum <= (acc_re == '0) && (acc_im == '0);
      if (acc_re < 0) begin
        x <= -re_ext;
        y <= -im_ext;
        z <= (acc_im >= 0) ? (Z_W'(1) <<< 31) : -(Z_W'(1) <<< 31);
      end else begin
        x <= re_ext;
        y <= im_ext;
        z <= '0;
      end
    end else if (cmd.step) begin
      if (sigma) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - ang;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + ang;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_lo) begin
      prod <= pss_pkg::PROD_W'(mprod);
    end else if (cmd.mul_hi) begin
      prod <= prod + (pss_pkg::PROD_W'(mprod) <<< pss_pkg::LO_W);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load_vec) begin
      acc_re <= '0;
      acc_im <= '0;
    end else begin
      if (cmd.acc_re) begin
        acc_re <= acc_re + ACC_W'(rnd);
      end
      if (cmd.acc_im) begin
        acc_im <= acc_im + ACC_W'(rnd);
      end
    end
  end

  always_comb begin
    if (rnd < 0) begin
      mag_sat = '0;
    end else if (rnd > $signed(pss_pkg::RND_W'(pss_pkg::MAG_MAX))) begin
      mag_sat = pss_pkg::MAG_MAX;
    end else begin
      mag_sat = rnd[pss_pkg::SMAG_W-1:0];
    end
    z_rnd = z + Z_W'(32768);
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res.sum_magnitude <= zero_sum ? '0 : mag_sat;
      res.sum_phase     <= zero_sum ? '0 : z_rnd[31:16];
      res.last_bin      <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (cmd.out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  assign result.data   = res;
  assign stat.out_busy = result.valid && !result.ready;

`ifndef ASSERT_OFF
  a_vec_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.load_vec |=> (acc_re == '0) && (acc_im == '0))
    else $error("accumulators not cleared when the bin closed");
`endif

endmodule

// ===== rtl/phasor_spectrum_sum_top.sv =====
// An item that does not close a bin is accepted, rotated through the CORDIC steps,
//   multiplied by the gain (low and high halves of x, then of y) and accumulated;
//   one CORDIC unit is shared by rotation and vectoring. An item that closes a bin
//   adds the vectoring load and steps, the split gain multiply and the result write.
//   Items are taken only when idle, after the last is through; the result register
//   lets the next item start while a result waits. Reset (rst, synchronous) clears
//   control, the accumulators and the bin count, and sets input_count to 2.
// ----------------------------------------------------------------------------
// phasor_spectrum_sum_top
// Sums one spectral bin, given as magnitude and phase, over input_count spectra.
// Each beat is rotated to cartesian form by CORDIC and added into real and
// imaginary accumulators; the closing beat triggers CORDIC vectoring back to
// magnitude and phase, which leave on the result channel with the last-bin mark.
// ----------------------------------------------------------------------------
module phasor_spectrum_sum_top #(
  parameter int MAX_INPUTS   = pss_pkg::MAX_INPUTS_DEF,  // bin size clamp, 1..64
  parameter int CORDIC_STEPS = pss_pkg::CORDIC_STEPS_DEF // micro-rotations, 8..24
) (
  input  logic       clk,
  input  logic       rst,
  pss_chan_if.sink   spectrum,  // in_item_t beats
  pss_chan_if.source result,    // out_item_t beats
  pss_chan_if.sink   cfg        // input_count writes
);

  pss_pkg::cmd_t  cmd;   // sequencer commands
  pss_pkg::stat_t stat;  // result register occupancy
  logic           in_ready;

  // Drive ready from the sequencer; only the idle state takes a beat
  assign spectrum.ready = in_ready;

  // Sequencer and configuration register
  pss_ctrl #(
    .MAX_INPUTS  (MAX_INPUTS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(spectrum.valid),
    .in_ready(in_ready),
    .cfg     (cfg),
    .cmd     (cmd),
    .stat    (stat)
  );

  // CORDIC, multiplier, accumulators and result register
  pss_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .in_data(spectrum.data),
    .cmd    (cmd),
    .stat   (stat),
    .result (result)
  );

endmodule
